[src/lfe_pkg.sv]
// Package for the linear fade envelope unit: payload structs, register
// indexes, controller states and the fixed field widths.
// No dependencies.
`default_nettype none

package lfe_pkg;

  // Width of the sample fields and of the configuration data word.
  localparam int SAMPLE_BITS = 24;
  localparam int CFG_DATA_BITS = 32;

  // Default width of the frame counter and of the stored frame counts.
  localparam int FRAME_BITS_DEF = 32;

  // Fade-in length after reset: half a second at 48 kHz.
  localparam int FADE_IN_RESET = 24000;

  typedef enum logic [1:0] {
    REG_TOTAL_FRAMES    = 2'd0,
    REG_FADE_IN_FRAMES  = 2'd1,
    REG_FADE_OUT_FRAMES = 2'd2,
    REG_BYPASS          = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WINDOW,
    ST_FADE_IN,
    ST_FADE_OUT,
    ST_DONE
  } lfe_state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_of_frame;
  } lfe_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          frame_end_out;
  } lfe_out_t;

endpackage

`default_nettype wire

[src/linear_fade_envelope_unit.sv]
// The result passes through the setup and window states, one bit-serial pass for each active
// fade window, and the done state, which loads the output register.
// One transaction at a time; the next one is taken once the result is in the output register.
// Each fade pass runs in the bit-serial multiply-divide unit, one magnitude bit per cycle.
// Reset (synchronous, rst_n low): controller, configuration and output valid to their reset values, position to zero.
// Top level of the linear fade envelope unit; depends on lfe_pkg.
`default_nettype none

module linear_fade_envelope_unit #(
  parameter int FRAME_BITS = lfe_pkg::FRAME_BITS_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  // Input channel
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  lfe_pkg::lfe_in_t                        in_data,
  // Result channel
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output lfe_pkg::lfe_out_t                       out_data,
  // Configuration write port
  input  wire                                     cfg_write_en,
  input  lfe_pkg::cfg_idx_t                       cfg_index,
  input  wire [lfe_pkg::CFG_DATA_BITS-1:0]        cfg_wdata
);

  import lfe_pkg::*;

  localparam int CNT_W = $clog2(SAMPLE_BITS);

  // Configuration registers. The frame counts keep the low FRAME_BITS bits
  // of the written word.
  logic [FRAME_BITS-1:0] total_r;
  logic [FRAME_BITS-1:0] fade_in_r;
  logic [FRAME_BITS-1:0] fade_out_r;
  logic                  bypass_r;

  // Frame position, advanced after the last channel sample of a frame.
  logic [FRAME_BITS-1:0] pos_r;

  lfe_state_t state_r, state_nxt;

  // Working registers for the transaction in progress.
  logic                   neg_r;
  logic                   eof_r;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [FRAME_BITS-1:0]  fin_r;
  logic [FRAME_BITS-1:0]  fout_r;
  logic [FRAME_BITS-1:0]  tail_r;
  logic                   win_out_r;

  // Bit-serial multiply-divide unit. It computes floor(mag * mul / div)
  // for mul <= div, taking one magnitude bit per cycle from the top. The
  // remainder stays below div, so each step yields a quotient digit of
  // 0, 1 or 2.
  logic [FRAME_BITS-1:0]  mul_r;
  logic [FRAME_BITS-1:0]  div_r;
  logic [FRAME_BITS-1:0]  rem_r;
  logic [SAMPLE_BITS-1:0] quo_r;
  logic [CNT_W-1:0]       cnt_r;

  logic                   out_valid_r;
  lfe_out_t               out_data_r;

  // Combinational signals.
  logic                   out_load;
  logic                   step_last;
  logic [FRAME_BITS+1:0]  step_sum;
  logic [FRAME_BITS+1:0]  div_x1;
  logic [FRAME_BITS+1:0]  div_x2;
  logic [FRAME_BITS-1:0]  rem_nxt;
  logic [1:0]             digit;
  logic [SAMPLE_BITS-1:0] quo_nxt;
  logic                   in_neg;
  logic [SAMPLE_BITS-1:0] in_mag;
  logic [FRAME_BITS-1:0]  tail_sub;
  logic [FRAME_BITS-1:0]  fout_start;
  logic                   win_in;
  logic                   win_out;

  // Sign and magnitude of the incoming sample. The most negative value
  // maps to a magnitude of 2^(SAMPLE_BITS-1), which still fits unsigned.
  assign in_neg = in_data.sample_in[SAMPLE_BITS-1];
  assign in_mag = in_neg ? (~in_data.sample_in + 1'b1) : in_data.sample_in;

  // Fade windows for the current frame position. The fade-out start never
  // wraps, because the clamped fade-out length is at most total_frames.
  assign tail_sub   = total_r - pos_r;
  assign fout_start = total_r - fout_r;
  assign win_in     = (pos_r < fin_r);
  assign win_out    = (pos_r >= fout_start) && (pos_r < total_r);

  // One step of the multiply-divide unit: shift the remainder, add the
  // multiplier when the next magnitude bit is set, then take off as many
  // divisors as fit, at most two.
  assign step_sum = {1'b0, rem_r, 1'b0} + (mag_r[SAMPLE_BITS-1] ? {2'b00, mul_r} : '0);
  assign div_x1   = {2'b00, div_r};
  assign div_x2   = {1'b0, div_r, 1'b0};

  always_comb begin
    if (step_sum >= div_x2) begin
      digit   = 2'd2;
      rem_nxt = FRAME_BITS'(step_sum - div_x2);
    end else if (step_sum >= div_x1) begin
      digit   = 2'd1;
      rem_nxt = FRAME_BITS'(step_sum - div_x1);
    end else begin
      digit   = 2'd0;
      rem_nxt = step_sum[FRAME_BITS-1:0];
    end
  end

  assign quo_nxt   = {quo_r[SAMPLE_BITS-2:0], 1'b0} + SAMPLE_BITS'(digit);
  assign step_last = (cnt_r == CNT_W'(SAMPLE_BITS - 1));

  // Controller state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake outputs. A new transaction is taken whenever
  // the controller is idle; a finished result waits in ST_DONE only until
  // the output register is free.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_WINDOW;
      end
      ST_WINDOW: begin
        if (bypass_r) begin
          state_nxt = ST_DONE;
        end else if (win_in) begin
          state_nxt = ST_FADE_IN;
        end else if (win_out) begin
          state_nxt = ST_FADE_OUT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_FADE_IN: begin
        if (step_last) begin
          state_nxt = win_out_r ? ST_FADE_OUT : ST_DONE;
        end
      end
      ST_FADE_OUT: begin
        if (step_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Configuration, frame position and output valid. Any configuration
  // write restarts the stimulus at frame zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      fade_in_r   <= FRAME_BITS'(FADE_IN_RESET);
      fade_out_r  <= '0;
      bypass_r    <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_TOTAL_FRAMES:    total_r    <= cfg_wdata[FRAME_BITS-1:0];
          REG_FADE_IN_FRAMES:  fade_in_r  <= cfg_wdata[FRAME_BITS-1:0];
          REG_FADE_OUT_FRAMES: fade_out_r <= cfg_wdata[FRAME_BITS-1:0];
          REG_BYPASS:          bypass_r   <= cfg_wdata[0];
          default:             bypass_r   <= bypass_r;
        endcase
        pos_r <= '0;
      end else if (out_load && eof_r) begin
        pos_r <= pos_r + 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          neg_r <= in_neg;
          mag_r <= in_mag;
          eof_r <= in_data.end_of_frame;
        end
      end
      ST_SETUP: begin
        // Both fade lengths are clamped to the stimulus length.
        fin_r  <= (fade_in_r < total_r) ? fade_in_r : total_r;
        fout_r <= (fade_out_r < total_r) ? fade_out_r : total_r;
      end
      ST_WINDOW: begin
        win_out_r <= win_out;
        tail_r    <= tail_sub;
        cnt_r     <= '0;
        rem_r     <= '0;
        quo_r     <= '0;
        if (win_in) begin
          mul_r <= pos_r;
          div_r <= fin_r;
        end else begin
          mul_r <= tail_sub;
          div_r <= fout_r;
        end
      end
      ST_FADE_IN, ST_FADE_OUT: begin
        if (step_last) begin
          // The quotient becomes the magnitude for the fade-out pass or the output.
          mag_r <= quo_nxt;
          cnt_r <= '0;
          rem_r <= '0;
          quo_r <= '0;
          mul_r <= tail_r;
          div_r <= fout_r;
        end else begin
          mag_r <= {mag_r[SAMPLE_BITS-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_data_r.sample_out    <= neg_r ? (~mag_r + 1'b1) : mag_r;
          out_data_r.frame_end_out <= eof_r;
        end
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The running remainder stays below the divisor in every serial step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FADE_IN || state_r == ST_FADE_OUT) |-> (rem_r < div_r))
    else $error("multiply-divide remainder reached the divisor");

  // A fade pass never starts with an empty window, so the divisor is nonzero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FADE_IN || state_r == ST_FADE_OUT) |-> (div_r != '0))
    else $error("fade pass running with a zero divisor");

  // The multiplier never exceeds the divisor, which bounds the quotient digit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FADE_IN || state_r == ST_FADE_OUT) |-> (mul_r <= div_r))
    else $error("fade gain above unity");

  // A configuration write returns the position to frame zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write_en |=> (pos_r == '0))
    else $error("frame position not cleared by a configuration write");
`endif

endmodule

`default_nettype wire
